// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the aggregator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BCMA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BCMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bcma_pkg.sv =====
// Package for the battery cell monitor aggregator: sizes, channel codes,
// conversion constants and the controller state type. No dependencies.
`timescale 1ns / 1ps

package bcma_pkg;

    localparam int NUM_CELLS   = 16;
    localparam int NUM_SENSORS = 2;
    localparam int CELL_AW     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int SENS_AW     = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    localparam logic       REQ_REPORT = 1'b0;
    localparam logic       REQ_TICK   = 1'b1;
    localparam logic [7:0] CH_SENSOR0 = 8'd17;
    localparam logic [7:0] CH_SENSOR1 = 8'd18;
    localparam logic [7:0] CH_BALANCE = 8'hff;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] CODE_MAX      = 16'hffff;

    localparam logic [17:0] SEEN_FULL =
        18'(((1 << NUM_CELLS) - 1) | (((1 << NUM_SENSORS) - 1) << 16));

    localparam logic signed [11:0] TEMP_LOW_RESET  = 12'sd2000;
    localparam logic signed [11:0] TEMP_HIGH_RESET = -12'sd2000;
    localparam logic signed [11:0] TEMP_MAX        = 12'sd2000;
    localparam logic signed [11:0] TEMP_MIN        = -12'sd2000;

    // Resistance polynomial, scaled by 1e16
    localparam logic [28:0]        K_A   = 29'd347363427;
    localparam logic [43:0]        K_B   = 44'd10257707629030;
    localparam logic signed [63:0] K_C_S = 64'sd26823534061433700;

    localparam logic signed [30:0] K_LN2_S   = 31'sd744261118;
    localparam logic signed [29:0] K_SLOPE_S = 30'sd305280964;
    localparam logic signed [63:0] K_OFF_Q24 = 64'sd956841501 <<< 24;
    localparam logic signed [63:0] K_DHALF   = 64'sd8388608000000;

    localparam logic signed [63:0] S_SAT_HI = 64'sd2001000000;
    localparam logic signed [63:0] S_SAT_LO = -64'sd2000000000;
    localparam logic signed [63:0] S_BIAS   = 64'sd2000000000;
    // ceil(2^50 / 1e6): exact quotient by one million for any 32-bit dividend
    localparam logic [30:0]        DIV_MAGIC = 31'd1125899907;
    localparam logic [12:0]        Q_BIAS    = 13'd2000;

    localparam int NORM_STEPS = 6;
    localparam int LOG_STEPS  = 24;

    // Elaboration-time log2 in Q24, same steps as the hardware unit
    function automatic logic [29:0] log2_q24_const(input logic [63:0] x);
        int          n;
        logic [63:0] m;
        logic [23:0] frac;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) n = i;
        end
        if (n >= 30) m = x >> (n - 30);
        else m = x << (30 - n);
        frac = '0;
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = {frac[22:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {6'(n), frac};
    endfunction

    localparam logic [29:0] L_E16 = log2_q24_const(64'd10000000000000000);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CELL_WR,
        ST_T_SQ,
        ST_T_PROD,
        ST_T_SUM,
        ST_T_NORM,
        ST_T_LOG,
        ST_T_LN,
        ST_T_NUM,
        ST_T_SCALE,
        ST_T_DIV,
        ST_S_WR,
        ST_WALK,
        ST_WLAST,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/bcma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bcma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/battery_cell_monitor_aggregator_top.sv =====
// Battery cell monitor aggregator top level: controller, temperature unit and
// cell walk. Depends on bcma_pkg, bcma_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each request is a report (channel, code) or a millisecond tick and yields one
// result. Cell state sits in a 16-entry RAM, sensor state in a 2-entry RAM, both
// with per-entry valid bits so no clearing pass runs after reset. Ticks, balance
// and unknown channels go straight to the walk over the 16 cell entries through
// the single RAM read port that builds the module low, high and sum; cell reports
// first write their entry. Sensor reports run a 6-step normalize, the logarithm
// at one squaring per cycle to a 24-bit fraction and a reciprocal multiply for
// the divide by one million, before the same walk; a saturated temperature skips
// the multiply and a zero or negative resistance skips the whole conversion. A
// new request is taken while the last result still waits in the output register.
module battery_cell_monitor_aggregator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // channel[7:0], raw_value[23:8]
    input  logic [0:0]   s_tuser,   // req_type[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_code_now[15:0], cell_code_min[31:16], cell_code_max[47:32],
    // temp_now[59:48], temp_min[71:60], temp_max[83:72], module_low_code[99:84],
    // module_high_code[115:100], module_sum_code[135:116], balance_bits[151:136]
    output logic [151:0] m_tdata,
    output logic [1:0]   m_tuser,   // temp_invalid[0], data_valid[1]
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    localparam int CAW = bcma_pkg::CELL_AW;
    localparam int SAW = bcma_pkg::SENS_AW;

    bcma_pkg::state_t state_reg, state_next;

    // decode of the offered request
    logic [7:0]  in_ch;
    logic [15:0] in_code;
    logic        in_tick, in_cell, in_sens, in_bal;

    logic [15:0]    code_reg, code_next;
    logic [CAW-1:0] cidx_reg, cidx_next;
    logic [SAW-1:0] sidx_reg, sidx_next;

    logic [bcma_pkg::NUM_CELLS-1:0]   cvld_reg, cvld_next;
    logic [bcma_pkg::NUM_SENSORS-1:0] svld_reg, svld_next;
    logic [15:0] bal_reg, bal_next;
    logic [17:0] seen_reg, seen_next;
    logic [15:0] ms_reg, ms_next;
    logic [15:0] timeout_reg;

    // temperature unit
    logic [31:0]        dd_reg, dd_next;
    logic [60:0]        p1_reg, p1_next;
    logic [59:0]        p2_reg, p2_next;
    logic [63:0]        x_reg, x_next;
    logic [5:0]         lz_reg, lz_next;
    logic [2:0]         step_reg, step_next;
    logic [30:0]        m_reg, m_next;
    logic [23:0]        frac_reg, frac_next;
    logic [4:0]         lcnt_reg, lcnt_next;
    logic signed [61:0] prod_reg, prod_next;
    logic signed [63:0] num_reg, num_next;
    logic [31:0]        rem_reg, rem_next;
    logic signed [11:0] t_reg, t_next;
    logic               tinv_reg, tinv_next;

    logic signed [63:0] r_sum;
    logic               r_pos;
    logic [63:0]        xs;
    logic [5:0]         lzs;
    logic [61:0]        sq;
    logic [31:0]        sq_hi;
    logic [5:0]         lg_int;
    logic signed [30:0] ldiff;
    logic signed [31:0] lnr;
    logic signed [63:0] slope_term;
    logic signed [63:0] s_full;
    logic               sat_hi, sat_lo;
    logic [61:0]        qprod;

    // per-channel result fields
    logic [15:0]        rc_now_reg, rc_now_next, rc_min_reg, rc_min_next;
    logic [15:0]        rc_max_reg, rc_max_next;
    logic signed [11:0] rt_now_reg, rt_now_next, rt_min_reg, rt_min_next;
    logic signed [11:0] rt_max_reg, rt_max_next;
    logic               rt_inv_reg, rt_inv_next;

    // cell walk
    logic [CAW-1:0] wcnt_reg, wcnt_next;
    logic           rpend_reg, rpend_next;
    logic           rvld_reg, rvld_next;
    logic [15:0]    alow_reg, alow_next, ahigh_reg, ahigh_next;
    logic [19:0]    asum_reg, asum_next;
    logic [15:0]    wval;

    // cell entry: {high, low, now}; sensor entry: {high, low, now}
    logic           cram_we;
    logic [CAW-1:0] cram_raddr;
    logic [47:0]    cram_wdata, cram_rdata, cell_cur;
    logic [15:0]    c_low, c_high;
    logic           sram_we;
    logic [35:0]    sram_wdata, sram_rdata, sens_cur;
    logic signed [11:0] s_now, s_low, s_high;

    logic           m_tvalid_reg, m_tvalid_next;
    logic [151:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]     m_tuser_reg, m_tuser_next;
    logic           out_load;
    logic           dvalid;

    assign in_ch   = s_tdata[7:0];
    assign in_code = s_tdata[23:8];
    assign in_tick = (s_tuser[0] == bcma_pkg::REQ_TICK);
    assign in_cell = !in_tick && (in_ch < 8'(bcma_pkg::NUM_CELLS));
    assign in_sens = !in_tick && ((in_ch == bcma_pkg::CH_SENSOR0)
                                  || (in_ch == bcma_pkg::CH_SENSOR1))
                     && ((in_ch - bcma_pkg::CH_SENSOR0) < 8'(bcma_pkg::NUM_SENSORS));
    assign in_bal  = !in_tick && (in_ch == bcma_pkg::CH_BALANCE);

    assign s_tready = (state_reg == bcma_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_load = (state_reg == bcma_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    assign dvalid   = ((seen_reg & bcma_pkg::SEEN_FULL) == bcma_pkg::SEEN_FULL)
                      && (ms_reg <= timeout_reg);

    assign cram_raddr = (state_reg == bcma_pkg::ST_WALK) ? wcnt_reg : in_ch[CAW-1:0];

    bcma_ram #(.WIDTH(48), .DEPTH(bcma_pkg::NUM_CELLS)) u_cell_ram (
        .aclk  (aclk),
        .we    (cram_we),
        .waddr (cidx_reg),
        .wdata (cram_wdata),
        .raddr (cram_raddr),
        .rdata (cram_rdata)
    );

    bcma_ram #(.WIDTH(36), .DEPTH(bcma_pkg::NUM_SENSORS)) u_sens_ram (
        .aclk  (aclk),
        .we    (sram_we),
        .waddr (sidx_reg),
        .wdata (sram_wdata),
        .raddr (sidx_reg),
        .rdata (sram_rdata)
    );

    // stored entries, reset value where never written
    assign cell_cur = cvld_reg[cidx_reg] ? cram_rdata : {16'h0000, bcma_pkg::CODE_MAX, 16'h0000};
    assign sens_cur = svld_reg[sidx_reg] ? sram_rdata
                      : {bcma_pkg::TEMP_HIGH_RESET, bcma_pkg::TEMP_LOW_RESET, 12'sd0};
    assign c_low  = (code_reg < cell_cur[31:16]) ? code_reg : cell_cur[31:16];
    assign c_high = (code_reg > cell_cur[47:32]) ? code_reg : cell_cur[47:32];
    assign s_now  = tinv_reg ? $signed(sens_cur[11:0]) : t_reg;
    assign s_low  = (!tinv_reg && (t_reg < $signed(sens_cur[23:12]))) ? t_reg
                    : $signed(sens_cur[23:12]);
    assign s_high = (!tinv_reg && (t_reg > $signed(sens_cur[35:24]))) ? t_reg
                    : $signed(sens_cur[35:24]);

    // temperature datapath pieces
    assign r_sum = $signed({3'b000, p1_reg}) - $signed({4'b0000, p2_reg}) + bcma_pkg::K_C_S;
    assign r_pos = (r_sum > 64'sd0);
    assign sq     = 62'(m_reg) * 62'(m_reg);
    assign sq_hi  = sq[61:30];
    assign lg_int = 6'd63 - lz_reg;
    assign ldiff  = $signed({1'b0, lg_int, frac_reg}) - $signed({1'b0, bcma_pkg::L_E16});
    assign lnr    = prod_reg[61:30];
    assign slope_term = lnr * bcma_pkg::K_SLOPE_S;
    assign s_full = (num_reg + bcma_pkg::K_DHALF) >>> 24;
    assign sat_hi = (s_full >= bcma_pkg::S_SAT_HI);
    assign sat_lo = (s_full < bcma_pkg::S_SAT_LO);
    // quotient by one million sits in bits 61:50
    assign qprod  = 62'(rem_reg) * 62'(bcma_pkg::DIV_MAGIC);
    assign wval   = rvld_reg ? cram_rdata[15:0] : 16'h0000;

    // leading-zero search, halving the step each cycle
    always_comb begin
        xs  = x_reg;
        lzs = lz_reg;
        case (step_reg)
            3'd0: if (x_reg[63:32] == '0) begin xs = x_reg << 32; lzs = lz_reg + 6'd32; end
            3'd1: if (x_reg[63:48] == '0) begin xs = x_reg << 16; lzs = lz_reg + 6'd16; end
            3'd2: if (x_reg[63:56] == '0) begin xs = x_reg << 8; lzs = lz_reg + 6'd8; end
            3'd3: if (x_reg[63:60] == '0) begin xs = x_reg << 4; lzs = lz_reg + 6'd4; end
            3'd4: if (x_reg[63:62] == '0) begin xs = x_reg << 2; lzs = lz_reg + 6'd2; end
            default: if (!x_reg[63]) begin xs = x_reg << 1; lzs = lz_reg + 6'd1; end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bcma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_cell) state_next = bcma_pkg::ST_CELL_WR;
                    else if (in_sens) state_next = bcma_pkg::ST_T_SQ;
                    else state_next = bcma_pkg::ST_WALK;
                end
            end
            bcma_pkg::ST_CELL_WR: state_next = bcma_pkg::ST_WALK;
            bcma_pkg::ST_T_SQ:    state_next = bcma_pkg::ST_T_PROD;
            bcma_pkg::ST_T_PROD:  state_next = bcma_pkg::ST_T_SUM;
            bcma_pkg::ST_T_SUM:   state_next = r_pos ? bcma_pkg::ST_T_NORM : bcma_pkg::ST_S_WR;
            bcma_pkg::ST_T_NORM: begin
                if (step_reg == 3'(bcma_pkg::NORM_STEPS - 1)) state_next = bcma_pkg::ST_T_LOG;
            end
            bcma_pkg::ST_T_LOG: begin
                if (lcnt_reg == 5'(bcma_pkg::LOG_STEPS - 1)) state_next = bcma_pkg::ST_T_LN;
            end
            bcma_pkg::ST_T_LN:    state_next = bcma_pkg::ST_T_NUM;
            bcma_pkg::ST_T_NUM:   state_next = bcma_pkg::ST_T_SCALE;
            bcma_pkg::ST_T_SCALE: begin
                state_next = (sat_hi || sat_lo) ? bcma_pkg::ST_S_WR : bcma_pkg::ST_T_DIV;
            end
            bcma_pkg::ST_T_DIV: state_next = bcma_pkg::ST_S_WR;
            bcma_pkg::ST_S_WR: state_next = bcma_pkg::ST_WALK;
            bcma_pkg::ST_WALK: begin
                if (wcnt_reg == CAW'(bcma_pkg::NUM_CELLS - 1)) state_next = bcma_pkg::ST_WLAST;
            end
            bcma_pkg::ST_WLAST: state_next = bcma_pkg::ST_OUT;
            bcma_pkg::ST_OUT: begin
                if (out_load) state_next = bcma_pkg::ST_IDLE;
            end
            default: state_next = bcma_pkg::ST_IDLE;
        endcase
    end

    // datapath and state updates
    always_comb begin
        code_next = code_reg;   cidx_next = cidx_reg;   sidx_next = sidx_reg;
        cvld_next = cvld_reg;   svld_next = svld_reg;
        bal_next  = bal_reg;    seen_next = seen_reg;   ms_next = ms_reg;
        dd_next = dd_reg;       p1_next = p1_reg;       p2_next = p2_reg;
        x_next = x_reg;         lz_next = lz_reg;       step_next = step_reg;
        m_next = m_reg;         frac_next = frac_reg;   lcnt_next = lcnt_reg;
        prod_next = prod_reg;   num_next = num_reg;
        rem_next = rem_reg;
        t_next = t_reg;         tinv_next = tinv_reg;
        rc_now_next = rc_now_reg; rc_min_next = rc_min_reg; rc_max_next = rc_max_reg;
        rt_now_next = rt_now_reg; rt_min_next = rt_min_reg; rt_max_next = rt_max_reg;
        rt_inv_next = rt_inv_reg;
        wcnt_next = wcnt_reg;   rpend_next = 1'b0;      rvld_next = rvld_reg;
        alow_next = alow_reg;   ahigh_next = ahigh_reg; asum_next = asum_reg;
        cram_we = 1'b0;         cram_wdata = {c_high, c_low, code_reg};
        sram_we = 1'b0;         sram_wdata = {s_high, s_low, s_now};
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // fold in the cell read issued last cycle
        if (rpend_reg) begin
            if (wval < alow_reg) alow_next = wval;
            if (wval > ahigh_reg) ahigh_next = wval;
            asum_next = asum_reg + 20'(wval);
        end

        case (state_reg)
            bcma_pkg::ST_IDLE: begin
                wcnt_next  = '0;
                alow_next  = bcma_pkg::CODE_MAX;
                ahigh_next = '0;
                asum_next  = '0;
                if (s_tvalid) begin
                    code_next = in_code;
                    cidx_next = in_ch[CAW-1:0];
                    sidx_next = SAW'(in_ch - bcma_pkg::CH_SENSOR0);
                    tinv_next = 1'b0;
                    rc_now_next = '0; rc_min_next = '0; rc_max_next = '0;
                    rt_now_next = '0; rt_min_next = '0; rt_max_next = '0;
                    rt_inv_next = 1'b0;
                    if (in_tick) begin
                        if (ms_reg != bcma_pkg::CODE_MAX) ms_next = ms_reg + 16'd1;
                    end else if (in_cell) begin
                        seen_next = seen_reg | (18'd1 << in_ch[CAW-1:0]);
                        ms_next = '0;
                    end else if (in_sens) begin
                        seen_next = seen_reg | (18'd1 << (5'd16 + 5'(in_ch - bcma_pkg::CH_SENSOR0)));
                        ms_next = '0;
                    end else if (in_bal) begin
                        bal_next = in_code;
                        ms_next = '0;
                    end
                end
            end
            bcma_pkg::ST_CELL_WR: begin
                cram_we = 1'b1;
                cvld_next[cidx_reg] = 1'b1;
                rc_now_next = code_reg;
                rc_min_next = c_low;
                rc_max_next = c_high;
            end
            bcma_pkg::ST_T_SQ: dd_next = 32'(code_reg) * 32'(code_reg);
            bcma_pkg::ST_T_PROD: begin
                p1_next = 61'(bcma_pkg::K_A) * 61'(dd_reg);
                p2_next = 60'(bcma_pkg::K_B) * 60'(code_reg);
            end
            bcma_pkg::ST_T_SUM: begin
                x_next = r_sum;
                lz_next = '0;
                step_next = '0;
                tinv_next = !r_pos;
            end
            bcma_pkg::ST_T_NORM: begin
                x_next = xs;
                lz_next = lzs;
                step_next = step_reg + 3'd1;
                m_next = xs[63:33];
                frac_next = '0;
                lcnt_next = '0;
            end
            bcma_pkg::ST_T_LOG: begin
                m_next = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
                frac_next = {frac_reg[22:0], sq_hi[31]};
                lcnt_next = lcnt_reg + 5'd1;
            end
            bcma_pkg::ST_T_LN: prod_next = ldiff * bcma_pkg::K_LN2_S;
            bcma_pkg::ST_T_NUM: num_next = bcma_pkg::K_OFF_Q24 - slope_term;
            bcma_pkg::ST_T_SCALE: begin
                rem_next = 32'(s_full + bcma_pkg::S_BIAS);
                if (sat_hi) t_next = bcma_pkg::TEMP_MAX;
                else if (sat_lo) t_next = bcma_pkg::TEMP_MIN;
            end
            bcma_pkg::ST_T_DIV: begin
                t_next = $signed(12'({1'b0, qprod[61:50]} - bcma_pkg::Q_BIAS));
            end
            bcma_pkg::ST_S_WR: begin
                if (!tinv_reg) begin
                    sram_we = 1'b1;
                    svld_next[sidx_reg] = 1'b1;
                end
                rt_now_next = s_now;
                rt_min_next = s_low;
                rt_max_next = s_high;
                rt_inv_next = tinv_reg;
            end
            bcma_pkg::ST_WALK: begin
                rpend_next = 1'b1;
                rvld_next = cvld_reg[wcnt_reg];
                wcnt_next = wcnt_reg + CAW'(1);
            end
            bcma_pkg::ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {bal_reg, asum_reg, ahigh_reg, alow_reg,
                                    rt_max_reg, rt_min_reg, rt_now_reg,
                                    rc_max_reg, rc_min_reg, rc_now_reg};
                    m_tuser_next = {dvalid, rt_inv_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bcma_pkg::ST_IDLE;
            cvld_reg     <= '0;
            svld_reg     <= '0;
            bal_reg      <= '0;
            seen_reg     <= '0;
            ms_reg       <= '0;
            timeout_reg  <= bcma_pkg::TIMEOUT_RESET;
            rpend_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cvld_reg     <= cvld_next;
            svld_reg     <= svld_next;
            bal_reg      <= bal_next;
            seen_reg     <= seen_next;
            ms_reg       <= ms_next;
            rpend_reg    <= rpend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;  cidx_reg <= cidx_next;  sidx_reg <= sidx_next;
        dd_reg <= dd_next;      p1_reg <= p1_next;      p2_reg <= p2_next;
        x_reg <= x_next;        lz_reg <= lz_next;      step_reg <= step_next;
        m_reg <= m_next;        frac_reg <= frac_next;  lcnt_reg <= lcnt_next;
        prod_reg <= prod_next;  num_reg <= num_next;
        rem_reg <= rem_next;
        t_reg <= t_next;        tinv_reg <= tinv_next;
        rc_now_reg <= rc_now_next; rc_min_reg <= rc_min_next; rc_max_reg <= rc_max_next;
        rt_now_reg <= rt_now_next; rt_min_reg <= rt_min_next; rt_max_reg <= rt_max_next;
        rt_inv_reg <= rt_inv_next;
        wcnt_reg <= wcnt_next;  rvld_reg <= rvld_next;
        alow_reg <= alow_next;  ahigh_reg <= ahigh_next; asum_reg <= asum_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    `BCMA_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, state_reg != bcma_pkg::ST_IDLE, "request accepted but controller stayed idle")
    `BCMA_ASSERT_NOW(a_mantissa_norm, aclk, aresetn, state_reg == bcma_pkg::ST_T_LOG, m_reg[30], "log mantissa lost normalization")
    `BCMA_ASSERT_NOW(a_temp_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[59:48]) >= -12'sd2000) && ($signed(m_tdata[59:48]) <= 12'sd2000), "temperature result out of range")
    `BCMA_ASSERT_NEXT(a_timer_sat, aclk, aresetn, ms_reg == 16'hffff, (ms_reg == 16'hffff) || (ms_reg == 16'h0000), "report timer wrapped")

endmodule
